// ===== rtl/core/local_history_branch_predictor_assert.svh =====
// Assertion macros used by the port-level predictor checker.
`ifndef LOCAL_HISTORY_BRANCH_PREDICTOR_ASSERT_SVH
`define LOCAL_HISTORY_BRANCH_PREDICTOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LHBP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Delayed implication: the consequent is checked after the antecedent, on the rising clock edge.
`define LHBP_ASSERT_TWO_LATER(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
      else $error("%m: check failed");

`endif

// ===== rtl/core/lhbp_pkg.sv =====
// Package with shared constants and types of the local history branch predictor.
package lhbp_pkg;

   localparam int LHBP_INDEX_BITS = 6;
   localparam int LHBP_HIST_BITS  = 4;

   localparam logic ACT_PREDICT = 1'b0;
   localparam logic ACT_RESOLVE = 1'b1;

   localparam logic [1:0] CTR_MIN = 2'd0;
   localparam logic [1:0] CTR_MAX = 2'd3;

   localparam logic [31:0] PC_STEP = 32'd4;

   typedef struct packed {
      logic        action;
      logic [31:0] pc;
      logic [31:0] target;
      logic        taken;
      logic        correct;
   } lhbp_req_type;

endpackage

// ===== rtl/core/local_history_branch_predictor.sv =====
// Result: a predict beat is held in the input register, then its result in the result register.
// Throughput: one beat (predict or resolve) per cycle; busy is low whenever reset is low.
// Path: table read registered at accept, update and result computed in the next cycle.
// Back-to-back beats to the same entry see the pending update through a bypass register.
// Reset (synchronous, active high) clears all per-entry valid bits, so every entry reads
// as zero until first written; no clearing pass is needed.
module local_history_branch_predictor import lhbp_pkg::*; #(
   parameter int INDEX_BITS = LHBP_INDEX_BITS,
   parameter int HIST_BITS  = LHBP_HIST_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [31:0] req_pc,
   input  logic [31:0] req_target,
   input  logic        req_taken,
   input  logic        req_correct,
   output logic        rsp_valid,
   output logic        rsp_predict_taken,
   output logic [31:0] rsp_next_pc
);

   localparam int DEPTH = 1 << INDEX_BITS;
   localparam int NCTR  = 1 << HIST_BITS;
   localparam int PAT_W = 2 * NCTR;
   localparam int ENT_W = PAT_W + 2 * HIST_BITS;

   logic                  accept;
   logic [INDEX_BITS-1:0] req_idx;
   logic [INDEX_BITS-1:0] s1_idx;

   logic [ENT_W-1:0]      mem [DEPTH];
   logic [DEPTH-1:0]      vld_ff;

   lhbp_req_type          s1_ff;
   logic                  s1_valid_ff;
   logic [ENT_W-1:0]      rd_ff;
   logic                  rd_vld_ff;
   logic                  byp_sel_ff;
   logic [ENT_W-1:0]      byp_ff;

   logic [ENT_W-1:0]      ent_cur;
   logic [ENT_W-1:0]      ent_new;
   logic [PAT_W-1:0]      pat;
   logic [PAT_W-1:0]      pat_upd;
   logic [HIST_BITS-1:0]  spec;
   logic [HIST_BITS-1:0]  tk;
   logic [1:0]            ctr_spec;
   logic [1:0]            ctr_tk;
   logic [1:0]            ctr_upd;
   logic                  pred;
   logic [HIST_BITS:0]    spec_ext;
   logic [HIST_BITS:0]    tk_ext;
   logic [HIST_BITS-1:0]  spec_pred;
   logic [HIST_BITS-1:0]  tk_new;

   logic                  rsp_valid_in;
   logic                  rsp_valid_ff;
   logic                  rsp_predict_taken_ff;
   logic [31:0]           rsp_next_pc_in;
   logic [31:0]           rsp_next_pc_ff;

   assign busy    = reset;
   assign accept  = start && !busy;
   assign req_idx = req_pc[INDEX_BITS-1:0];
   assign s1_idx  = s1_ff.pc[INDEX_BITS-1:0];

   // Input register and stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.action  <= req_action;
         s1_ff.pc      <= req_pc;
         s1_ff.target  <= req_target;
         s1_ff.taken   <= req_taken;
         s1_ff.correct <= req_correct;
         rd_vld_ff     <= vld_ff[req_idx];
         // Forward the update being written this edge to a beat on the same entry.
         byp_sel_ff    <= s1_valid_ff && (s1_idx == req_idx);
         byp_ff        <= ent_new;
      end
   end

   // Table read port.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[req_idx];
      end
   end

   // Table write port.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mem[s1_idx] <= ent_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (s1_valid_ff) begin
         vld_ff[s1_idx] <= 1'b1;
      end
   end

   // Entry update and prediction.
   always_comb begin
      ent_cur   = byp_sel_ff ? byp_ff : (rd_vld_ff ? rd_ff : '0);
      pat       = ent_cur[PAT_W-1:0];
      spec      = ent_cur[PAT_W +: HIST_BITS];
      tk        = ent_cur[PAT_W + HIST_BITS +: HIST_BITS];

      ctr_spec  = pat[{spec, 1'b0} +: 2];
      pred      = ctr_spec[1];
      spec_ext  = {spec, pred};
      spec_pred = spec_ext[HIST_BITS-1:0];

      ctr_tk    = pat[{tk, 1'b0} +: 2];
      if (s1_ff.taken) begin
         ctr_upd = (ctr_tk == CTR_MAX) ? ctr_tk : ctr_tk + 2'd1;
      end else begin
         ctr_upd = (ctr_tk == CTR_MIN) ? ctr_tk : ctr_tk - 2'd1;
      end
      for (int i = 0; i < NCTR; i++) begin
         pat_upd[2*i +: 2] = (HIST_BITS'(i) == tk) ? ctr_upd : pat[2*i +: 2];
      end
      tk_ext = {tk, s1_ff.taken};
      tk_new = tk_ext[HIST_BITS-1:0];

      if (s1_ff.action == ACT_PREDICT) begin
         ent_new = {tk, spec_pred, pat};
      end else begin
         // Misprediction: restart speculative history from the resolved one.
         ent_new = {tk_new, (s1_ff.correct ? spec : tk_new), pat_upd};
      end

      rsp_valid_in   = s1_valid_ff && (s1_ff.action == ACT_PREDICT);
      rsp_next_pc_in = pred ? s1_ff.target : s1_ff.pc + PC_STEP;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_predict_taken_ff <= pred;
         rsp_next_pc_ff       <= rsp_next_pc_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_predict_taken = rsp_predict_taken_ff;
   assign rsp_next_pc       = rsp_next_pc_ff;

endmodule

// ===== rtl/core/lhbp_checker.sv =====
// Port-level checker for the local history branch predictor, with its bind.
`include "local_history_branch_predictor_assert.svh"

module lhbp_checker import lhbp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_action,
   input logic [31:0] req_pc,
   input logic [31:0] req_target,
   input logic        req_taken,
   input logic        req_correct,
   input logic        rsp_valid,
   input logic        rsp_predict_taken,
   input logic [31:0] rsp_next_pc
);

   logic acc_predict;
   logic acc_resolve;

   assign acc_predict = start && !busy && (req_action == ACT_PREDICT);
   assign acc_resolve = start && !busy && (req_action == ACT_RESOLVE);

   // Every predict beat yields exactly one result, once it has passed the input and result registers.
   `LHBP_ASSERT_TWO_LATER(a_predict_rsp, clock, reset, acc_predict, rsp_valid)
   // A resolve beat never yields a result.
   `LHBP_ASSERT_TWO_LATER(a_resolve_quiet, clock, reset, acc_resolve, !rsp_valid)
   // No result without a predict beat behind it.
   `LHBP_ASSERT_IMPLY(a_rsp_source, clock, reset, rsp_valid, $past(acc_predict, 2))
   // Not-taken result falls through to the next sequential address.
   `LHBP_ASSERT_IMPLY(a_fall_through, clock, reset, rsp_valid && !rsp_predict_taken,
      rsp_next_pc == 32'($past(req_pc, 2) + PC_STEP))
   // Taken result goes to the target.
   `LHBP_ASSERT_IMPLY(a_taken_target, clock, reset, rsp_valid && rsp_predict_taken,
      rsp_next_pc == $past(req_target, 2))

endmodule

bind local_history_branch_predictor lhbp_checker u_lhbp_checker (.*);

// ===== bench/lhbp_checker.sv =====
// Checker for the local history branch predictor: tracks the tables and compares fetch results.
module lhbp_tb_checker import lhbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_action,
   input  logic [31:0] req_pc,
   input  logic [31:0] req_target,
   input  logic        req_taken,
   input  logic        req_correct,
   input  logic        rsp_valid,
   input  logic        rsp_predict_taken,
   input  logic [31:0] rsp_next_pc,
   output int          mismatches,
   output int          fetches_pending,
   output int          predicts_seen,
   output int          resolves_seen
);

   localparam int ENTRIES  = 1 << LHBP_INDEX_BITS;
   localparam int PATTERNS = 1 << LHBP_HIST_BITS;

   typedef logic [LHBP_HIST_BITS-1:0]  hist_type;
   typedef logic [LHBP_INDEX_BITS-1:0] entry_type;

   typedef struct packed {
      logic        predict_taken;
      logic [31:0] next_pc;
   } fetch_type;

   logic [1:0] sat_ctr [ENTRIES][PATTERNS];
   hist_type   spec_hist [ENTRIES];
   hist_type   outcome_hist [ENTRIES];
   fetch_type  expected_fetch [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic track_beat(input lhbp_req_type b);
      entry_type  e;
      hist_type   h;
      logic [1:0] c;
      fetch_type  f;
      e = b.pc[LHBP_INDEX_BITS-1:0];
      if (b.action == ACT_PREDICT) begin
         f.predict_taken = sat_ctr[e][spec_hist[e]][1];
         f.next_pc       = f.predict_taken ? b.target : b.pc + PC_STEP;
         spec_hist[e]    = hist_type'({spec_hist[e], f.predict_taken});
         expected_fetch.push_back(f);
         predicts_seen++;
      end else begin
         h = outcome_hist[e];
         c = sat_ctr[e][h];
         if (b.taken) begin
            if (c != CTR_MAX) c++;
         end else if (c != CTR_MIN) begin
            c--;
         end
         sat_ctr[e][h]   = c;
         outcome_hist[e] = hist_type'({h, b.taken});
         // a misprediction restarts speculation from the resolved history
         if (!b.correct) spec_hist[e] = outcome_hist[e];
         resolves_seen++;
      end
   endtask

   always @(posedge clock) begin
      fetch_type f;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            spec_hist[i]    = '0;
            outcome_hist[i] = '0;
            for (int j = 0; j < PATTERNS; j++) sat_ctr[i][j] = CTR_MIN;
         end
         expected_fetch.delete();
         mismatches    = 0;
         predicts_seen = 0;
         resolves_seen = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_fetch.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_next_pc, 32'd0);
            end else begin
               f = expected_fetch.pop_front();
               if (rsp_predict_taken !== f.predict_taken)
                  report_mismatch("predict_taken", 32'(rsp_predict_taken),
                                  32'(f.predict_taken));
               if (rsp_next_pc !== f.next_pc)
                  report_mismatch("next_pc", rsp_next_pc, f.next_pc);
            end
         end
         if (start && !busy)
            track_beat('{req_action, req_pc, req_target, req_taken, req_correct});
      end
      fetches_pending <= expected_fetch.size();
   end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the local history branch predictor: stimulus, watchdog and verdict.
module tb import lhbp_pkg::*; ();

   localparam int RANDOM_BEATS   = 1530;
   localparam int PHASE_BEATS    = 200;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int POOL           = 8;
   localparam int MAX_GAP        = 30;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        start       = 1'b0;
   logic        req_action  = ACT_PREDICT;
   logic [31:0] req_pc      = '0;
   logic [31:0] req_target  = '0;
   logic        req_taken   = 1'b0;
   logic        req_correct = 1'b0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_predict_taken;
   logic [31:0] rsp_next_pc;

   int mismatches;
   int fetches_pending;
   int predicts_seen;
   int resolves_seen;
   int idle_pct = 0;
   int quiet_cycles = 0;
   int slot_bias [POOL];

   logic [LHBP_INDEX_BITS-1:0] pool_entry [POOL] =
      '{6'd0, 6'd1, 6'd2, 6'd21, 6'd42, 6'd61, 6'd62, 6'd63};

   always #5 clock = ~clock;

   local_history_branch_predictor dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_pc            (req_pc),
      .req_target        (req_target),
      .req_taken         (req_taken),
      .req_correct       (req_correct),
      .rsp_valid         (rsp_valid),
      .rsp_predict_taken (rsp_predict_taken),
      .rsp_next_pc       (rsp_next_pc)
   );

   lhbp_tb_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_pc            (req_pc),
      .req_target        (req_target),
      .req_taken         (req_taken),
      .req_correct       (req_correct),
      .rsp_valid         (rsp_valid),
      .rsp_predict_taken (rsp_predict_taken),
      .rsp_next_pc       (rsp_next_pc),
      .mismatches        (mismatches),
      .fetches_pending   (fetches_pending),
      .predicts_seen     (predicts_seen),
      .resolves_seen     (resolves_seen)
   );

   function automatic lhbp_req_type make_beat(input logic action, input logic [31:0] pc,
                                              input logic [31:0] target, input logic taken,
                                              input logic correct);
      return '{action, pc, target, taken, correct};
   endfunction

   // random high bits, low bits pinned to one of the hot entries
   function automatic logic [31:0] pool_pc(input int slot);
      logic [31:0] r;
      r = $urandom();
      r[LHBP_INDEX_BITS-1:0] = pool_entry[slot];
      return r;
   endfunction

   task automatic send_beat(input lhbp_req_type b);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_action  <= b.action;
      req_pc      <= b.pc;
      req_target  <= b.target;
      req_taken   <= b.taken;
      req_correct <= b.correct;
      do @(posedge clock); while (busy);
   endtask

   // hold the sender until every predict has returned its fetch beat
   task automatic drain_fetches();
      start <= 1'b0;
      do @(posedge clock); while (fetches_pending != 0);
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", quiet_cycles);
         $display("FAIL local_history_branch_predictor");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      lhbp_req_type directed [$];
      lhbp_req_type b;
      int           sent;
      int           phase;
      int           slot;
      logic [31:0]  pc;
      logic         taken;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // pc wrap, target extremes, ignored fields on predict
      directed.push_back(make_beat(ACT_PREDICT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1));
      directed.push_back(make_beat(ACT_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0));
      directed.push_back(make_beat(ACT_PREDICT, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, 1'b1));
      // train entry 0 through aliased pcs until counter 0 predicts taken
      directed.push_back(make_beat(ACT_RESOLVE, 32'h0000_0100, 32'hFFFF_FFFF, 1'b1, 1'b1));
      repeat (4)
         directed.push_back(make_beat(ACT_RESOLVE, 32'h0000_0040, 32'h0000_0000, 1'b0, 1'b1));
      directed.push_back(make_beat(ACT_RESOLVE, 32'hFFFF_FFC0, 32'h0000_0000, 1'b1, 1'b1));
      directed.push_back(make_beat(ACT_PREDICT, 32'h8000_0000, 32'hA5A5_5A5C, 1'b0, 1'b0));
      // misprediction copies the resolved history into the speculative one
      directed.push_back(make_beat(ACT_RESOLVE, 32'h0000_0000, 32'h1234_5678, 1'b0, 1'b0));
      directed.push_back(make_beat(ACT_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1));
      directed.push_back(make_beat(ACT_RESOLVE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0));
      directed.push_back(make_beat(ACT_PREDICT, 32'h0000_003F, 32'h5A5A_A5A4, 1'b0, 1'b0));
      repeat (5)
         directed.push_back(make_beat(ACT_RESOLVE, 32'h0000_0005, 32'h0000_0000, 1'b1, 1'b1));
      directed.push_back(make_beat(ACT_PREDICT, 32'hC000_0005, 32'hFFFF_FFF0, 1'b0, 1'b1));
      foreach (directed[i]) send_beat(directed[i]);
      drain_fetches();

      sent  = 0;
      phase = -1;
      while (sent < RANDOM_BEATS) begin
         if ((sent / PHASE_BEATS) % 3 != phase) begin
            phase = (sent / PHASE_BEATS) % 3;
            drain_fetches();
            idle_pct = (phase == 0) ? 0 : (phase == 1) ? 47 : 23;
            // keep one always-taken and one never-taken slot to hit both saturation ends
            foreach (slot_bias[s]) slot_bias[s] = $urandom_range(0, 4);
            slot_bias[0] = 4;
            slot_bias[1] = 0;
         end
         if ($urandom_range(0, 99) < 70) begin
            slot = $urandom_range(0, POOL - 1);
            pc   = pool_pc(slot);
            send_beat(make_beat(ACT_PREDICT, pc, $urandom(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1))));
            taken = ($urandom_range(0, 3) < slot_bias[slot]);
            send_beat(make_beat(ACT_RESOLVE, pc, $urandom(), taken,
                                $urandom_range(0, 9) != 0));
            sent += 2;
         end else begin
            b = make_beat(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            send_beat(b);
            sent++;
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (fetches_pending != 0);
      repeat (4) @(posedge clock);

      $display("covered %0d predict and %0d resolve beats, directed then random",
               predicts_seen, resolves_seen);
      $display("random beats ran under three sender idle levels with drains between them");
      if (mismatches == 0 && fetches_pending == 0) begin
         $display("PASS local_history_branch_predictor");
      end else begin
         $display("FAIL local_history_branch_predictor");
      end
      $finish;
   end

endmodule

// ===== local_history_branch_predictor.f =====
+incdir+rtl/core
rtl/core/lhbp_pkg.sv
rtl/core/local_history_branch_predictor.sv
rtl/core/lhbp_checker.sv
bench/lhbp_checker.sv
bench/tb.sv
